// ----- src/lra_pkg.sv -----
package lra_pkg;

  localparam int unsigned RowWidth   = 50;
  localparam int unsigned TdataWidth = ((RowWidth + 7) / 8) * 8;
  localparam int unsigned NumSlots   = 3;

  // Result slots of one input beat, in delivery order
  localparam int unsigned SlotMid   = 0;  // row two above the new one
  localparam int unsigned SlotFlush = 1;  // row one above the bottom row
  localparam int unsigned SlotLast  = 2;  // bottom row of the frame

  typedef logic [RowWidth-1:0] row_t;

  // Five-row window captured with each accepted beat
  typedef struct packed {
    row_t                h3;
    row_t                h2;
    row_t                h1;
    row_t                h0;
    row_t                cur;
    logic [NumSlots-1:0] emit;
  } window_t;

endpackage

// ----- src/leaf_rule_automaton_row_step.sv -----
// Path: input beat -> window register -> result buffer -> result beat.
// Throughput: one input row per cycle while the result stream keeps up; a bottom row releases up to three
// result beats, drained one per cycle as the output takes them, and the input waits meanwhile.
// Reset: line buffers and row count cleared, no beats pending; the next states of three rows (mid,
// flush, last) are worked out for all columns at once between the window and result registers.
module leaf_rule_automaton_row_step (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lra_pkg::TdataWidth-1:0]  s_axis_tdata,   // row_cells
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lra_pkg::TdataWidth-1:0]  m_axis_tdata,   // next_row_cells
  output logic                            m_axis_tlast
);

  logic             accept;
  logic             win_valid;
  lra_pkg::window_t win;
  logic             buf_free;
  logic             load;
  lra_pkg::row_t    row_mid, row_flush, row_last, row_out;

  assign load          = win_valid && buf_free;
  assign s_axis_tready = !win_valid || load;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lra_row_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .row_i    (s_axis_tdata[lra_pkg::RowWidth-1:0]),
    .last_i   (s_axis_tlast),
    .adv_i    (load),
    .valid_o  (win_valid),
    .window_o (win)
  );

  lra_next_row u_row_mid (
    .a2_i   (win.h3),
    .a1_i   (win.h2),
    .c_i    (win.h1),
    .b1_i   (win.h0),
    .b2_i   (win.cur),
    .next_o (row_mid)
  );

  lra_next_row u_row_flush (
    .a2_i   (win.h2),
    .a1_i   (win.h1),
    .c_i    (win.h0),
    .b1_i   (win.cur),
    .b2_i   ('0),
    .next_o (row_flush)
  );

  lra_next_row u_row_last (
    .a2_i   (win.h1),
    .a1_i   (win.h0),
    .c_i    (win.cur),
    .b1_i   ('0),
    .b2_i   ('0),
    .next_o (row_last)
  );

  lra_result_buf u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .mask_i      (win.emit),
    .row_mid_i   (row_mid),
    .row_flush_i (row_flush),
    .row_last_i  (row_last),
    .free_o      (buf_free),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .row_o       (row_out),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(lra_pkg::TdataWidth - lra_pkg::RowWidth){1'b0}}, row_out};

endmodule

// ----- src/lra_next_row.sv -----
module lra_next_row (
  input  lra_pkg::row_t a2_i,
  input  lra_pkg::row_t a1_i,
  input  lra_pkg::row_t c_i,
  input  lra_pkg::row_t b1_i,
  input  lra_pkg::row_t b2_i,
  output lra_pkg::row_t next_o
);

  // centre row padded with two dead cells either side: c_i[k] sits at cp[k+2]
  logic [lra_pkg::RowWidth+3:0] cp;
  assign cp = {2'b00, c_i, 2'b00};

  for (genvar k = 0; k < lra_pkg::RowWidth; k++) begin : g_cell
    logic [3:0] semi;
    logic [3:0] full;
    logic [2:0] semi_cnt;

    assign semi[0] = a1_i[k] ^ a2_i[k];
    assign full[0] = a1_i[k] & a2_i[k];
    assign semi[1] = cp[k+3] ^ cp[k+4];
    assign full[1] = cp[k+3] & cp[k+4];
    assign semi[2] = b1_i[k] ^ b2_i[k];
    assign full[2] = b1_i[k] & b2_i[k];
    assign semi[3] = cp[k+1] ^ cp[k];
    assign full[3] = cp[k+1] & cp[k];

    assign semi_cnt = {2'b00, semi[0]} + {2'b00, semi[1]} + {2'b00, semi[2]}
                    + {2'b00, semi[3]};

    assign next_o[k] = c_i[k] ? ((full == 4'b0000) && (semi != 4'b0000))
                              : (semi_cnt == 3'd2);
  end

endmodule

// ----- src/lra_row_window.sv -----
module lra_row_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  lra_pkg::row_t     row_i,
  input  logic              last_i,
  input  logic              adv_i,
  output logic              valid_o,
  output lra_pkg::window_t  window_o
);

  localparam logic [1:0] PendingFull = 2'd2;

  lra_pkg::row_t    h0_q, h1_q, h2_q, h3_q;
  logic [1:0]       pending_q;
  logic             valid_q;
  lra_pkg::window_t win_q;
  logic [lra_pkg::NumSlots-1:0] emit;

  assign emit[lra_pkg::SlotMid]   = (pending_q == PendingFull);
  assign emit[lra_pkg::SlotFlush] = last_i && (pending_q != 2'd0);
  assign emit[lra_pkg::SlotLast]  = last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q      <= '0;
      h1_q      <= '0;
      h2_q      <= '0;
      h3_q      <= '0;
      pending_q <= 2'd0;
      valid_q   <= 1'b0;
    end else begin
      if (accept_i) begin
        valid_q <= 1'b1;
        if (last_i) begin
          // frame done: line buffers cleared for the next one
          h0_q      <= '0;
          h1_q      <= '0;
          h2_q      <= '0;
          h3_q      <= '0;
          pending_q <= 2'd0;
        end else begin
          h0_q <= row_i;
          h1_q <= h0_q;
          h2_q <= h1_q;
          h3_q <= h2_q;
          if (pending_q != PendingFull) begin
            pending_q <= pending_q + 2'd1;
          end
        end
      end else if (adv_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= '{h3: h3_q, h2: h2_q, h1: h1_q, h0: h0_q, cur: row_i, emit: emit};
    end
  end

  assign valid_o  = valid_q;
  assign window_o = win_q;

`ifndef SYNTHESIS
  a_pending_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("row count beyond saturation");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> (pending_q == 2'd0) && (h0_q == '0) && (h3_q == '0))
    else $error("line buffers not cleared after bottom row");
`endif

endmodule

// ----- src/lra_result_buf.sv -----
module lra_result_buf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  logic [lra_pkg::NumSlots-1:0]  mask_i,
  input  lra_pkg::row_t                 row_mid_i,
  input  lra_pkg::row_t                 row_flush_i,
  input  lra_pkg::row_t                 row_last_i,
  output logic                          free_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output lra_pkg::row_t                 row_o,
  output logic                          last_o
);

  logic [lra_pkg::NumSlots-1:0] v_q;
  logic [lra_pkg::NumSlots-1:0] first;
  lra_pkg::row_t                mid_q, flush_q, last_q;
  logic                         beat;

  // lowest pending slot goes out first
  assign first = v_q & ~(v_q - 3'd1);
  assign beat  = valid_o && ready_i;

  assign valid_o = (v_q != '0);
  assign last_o  = first[lra_pkg::SlotLast];
  assign row_o   = ({lra_pkg::RowWidth{first[lra_pkg::SlotMid]}}   & mid_q)
                 | ({lra_pkg::RowWidth{first[lra_pkg::SlotFlush]}} & flush_q)
                 | ({lra_pkg::RowWidth{first[lra_pkg::SlotLast]}}  & last_q);

  assign free_o = (v_q == '0) || (beat && ((v_q & ~first) == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (load_i) begin
      v_q <= mask_i;
    end else if (beat) begin
      v_q <= v_q & ~first;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mid_q   <= row_mid_i;
      flush_q <= row_flush_i;
      last_q  <= row_last_i;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result buffer overwritten while beats pending");

  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> (v_q == 3'b100))
    else $error("frame end sent ahead of pending rows");
`endif

endmodule
